[rtl/srpg_pkg.sv]
// Shared types and constants of the stepper ramp profile generator.
`default_nettype none
package srpg_pkg;

    // Timer tick rate that scales the step period.
    localparam int unsigned TICK_RATE = 40000;
    localparam int TICK_W = $clog2(TICK_RATE + 1);

    // Field widths.
    localparam int DIST_W  = 32;
    localparam int SPEED_W = 31;
    localparam int ACC_W   = 14;
    localparam int CFG_W   = 21;
    localparam int OP_W    = 2;

    // Square root: 21 result bits from a 42-bit radicand.
    localparam int ROOT_W     = 21;
    localparam int SQRT_STEPS = ROOT_W;
    localparam int RAD_W      = 2 * ROOT_W;

    // Division: (dv << 7) / accel_whole, 39-bit numerator.
    localparam int DV_W      = 32;
    localparam int NUM_W     = DV_W + 7;
    localparam int DIV_STEPS = NUM_W;

    // Period product r * (TICK_RATE * gain), scaled down by 2^41.
    localparam int TG_W       = TICK_W + CFG_W;
    localparam int MUL_STEPS  = TG_W;
    localparam int PROD_W     = NUM_W + TG_W;
    localparam int PER_SHIFT  = 41;

    localparam int CNT_MAX = (DIV_STEPS > MUL_STEPS) ? DIV_STEPS : MUL_STEPS;
    localparam int CNT_W   = $clog2(CNT_MAX);

    // Configuration port.
    localparam int CFG_ADDR_W = 8;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_ADDR_W-1:0] REG_STEP_DISTANCE = 8'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_PERIOD_GAIN   = 8'd1;
    localparam logic [CFG_W-1:0]      CFG_RESET_VALUE   = 21'd131072;

    // Opcodes.
    localparam logic [OP_W-1:0] OP_STEP_LEFT  = 2'd0;
    localparam logic [OP_W-1:0] OP_STEP_RIGHT = 2'd1;
    localparam logic [OP_W-1:0] OP_LOAD       = 2'd2;

    // Stream payload widths.
    localparam int IN_DATA_W  = 144;
    localparam int OUT_DATA_W = 96;
    localparam int OUT_USER_W = 3;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;
        logic latch;
        logic prep_a;
        logic prep_b;
        logic prep_c;
        logic root_step;
        logic root_end;
        logic div_step;
        logic div_end;
        logic mul_step;
        logic out_load;
    } t_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic cnt_zero;
    } t_stat;

endpackage
`default_nettype wire

[rtl/stepper_ramp_profile_generator_unit.sv]
// Top level of the two-motor stepper ramp profile generator.
// A step beat passes through the preparation states, the bit-serial square root, the restoring
// divider and the serial period multiplier to the output register; a load goes straight to it.
// One item is in flight at a time: no new item is accepted until the last result is registered.
// Synchronous active-low reset clears all motion state, sets both registers to 1.0 in Q17,
// and leaves the block idle with no result pending.
`default_nettype none
module stepper_ramp_profile_generator_unit (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // Input stream.
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // tdata from bit 0: move_distance[31:0], brake_distance[63:32], cruise_speed[94:64],
    // brake_speed[125:95], accel_whole[139:126], zero fill[143:140].
    input  wire [srpg_pkg::IN_DATA_W-1:0] i_s_axis_tdata,
    // tuser from bit 0: opcode[1:0].
    input  wire [srpg_pkg::OP_W-1:0]      i_s_axis_tuser,
    // Output stream.
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    // tdata from bit 0: step_period[31:0], speed_now[62:32], distance_left[94:63], zero[95].
    output logic [srpg_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,
    // tuser from bit 0: motor_index[0], is_step[1], brake_started[2].
    output logic [srpg_pkg::OUT_USER_W-1:0] o_m_axis_tuser,
    // Configuration write channel.
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire [srpg_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire [srpg_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import srpg_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    // Sequencer.
    srpg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .i_op        (i_s_axis_tuser),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // Arithmetic and state.
    srpg_datapath u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_op             (i_s_axis_tuser),
        .i_move_distance  (i_s_axis_tdata[31:0]),
        .i_brake_distance (i_s_axis_tdata[63:32]),
        .i_cruise_speed   (i_s_axis_tdata[94:64]),
        .i_brake_speed    (i_s_axis_tdata[125:95]),
        .i_accel_whole    (i_s_axis_tdata[139:126]),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_addr       (i_cfg_addr),
        .i_cfg_data       (i_cfg_data),
        .o_data           (o_m_axis_tdata),
        .o_user           (o_m_axis_tuser)
    );

endmodule
`default_nettype wire

[rtl/srpg_datapath.sv]
// Datapath of the ramp generator: motion state, square root, divider and multiplier.
`default_nettype none
module srpg_datapath (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  srpg_pkg::t_cmd                i_cmd,
    output srpg_pkg::t_stat               o_stat,
    input  wire [srpg_pkg::OP_W-1:0]      i_op,
    input  wire [srpg_pkg::DIST_W-1:0]    i_move_distance,
    input  wire [srpg_pkg::DIST_W-1:0]    i_brake_distance,
    input  wire [srpg_pkg::SPEED_W-1:0]   i_cruise_speed,
    input  wire [srpg_pkg::SPEED_W-1:0]   i_brake_speed,
    input  wire [srpg_pkg::ACC_W-1:0]     i_accel_whole,
    input  wire                           i_cfg_valid,
    input  wire [srpg_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire [srpg_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic [srpg_pkg::OUT_DATA_W-1:0] o_data,
    output logic [srpg_pkg::OUT_USER_W-1:0] o_user
);
    import srpg_pkg::*;

    // Configuration and motion state.
    logic [CFG_W-1:0]   r_step;
    logic [CFG_W-1:0]   r_gain;
    logic [DIST_W-1:0]  r_travel [2];
    logic [SPEED_W-1:0] r_speed [2];
    logic [DIST_W-1:0]  r_move;
    logic [DIST_W-1:0]  r_brake_at;
    logic [SPEED_W-1:0] r_goal;
    logic [SPEED_W-1:0] r_brake_goal;
    logic [ACC_W-1:0]   r_aw;
    logic               r_armed;

    // Per-item working registers.
    logic               r_m;
    logic               r_is_step;
    logic               r_started;
    logic [SPEED_W-1:0] r_old;
    logic [DIST_W-1:0]  r_rem;
    logic [33:0]        r_sq;
    logic [24:0]        r_as6;
    logic               r_accel;
    logic [RAD_W-1:0]   r_rad;
    logic [ROOT_W+1:0]  r_root_rem;
    logic [ROOT_W-1:0]  r_root;
    logic [SPEED_W-1:0] r_speed_out;
    logic [NUM_W-1:0]   r_num;
    logic [ACC_W-1:0]   r_div_rem;
    logic [PROD_W-1:0]  r_mul_a;
    logic [TG_W-1:0]    r_mul_b;
    logic [PROD_W-1:0]  r_acc;
    logic [CNT_W-1:0]   r_cnt;

    // Brake check on the left motor's remaining distance.
    logic [DIST_W-1:0] left_rem;
    logic [DIST_W-1:0] left_mag;
    logic              brake_fire;
    always_comb begin
        left_rem   = r_move - r_travel[0];
        left_mag   = left_rem[DIST_W-1] ? (DIST_W'(0) - left_rem) : left_rem;
        brake_fire = r_armed &&
            ($signed({r_brake_at[DIST_W-1], r_brake_at}) >= $signed({1'b0, left_mag}));
    end

    // Radicand of the speed update.
    logic [34:0] rad_sum;
    always_comb begin
        if (r_old < r_goal) begin
            rad_sum = {1'b0, r_sq} + {10'b0, r_as6};
        end else if (r_sq >= {9'b0, r_as6}) begin
            rad_sum = {1'b0, r_sq - {9'b0, r_as6}};
        end else begin
            rad_sum = '0;
        end
    end

    // One restoring square-root step: two radicand bits per cycle.
    logic [ROOT_W+3:0] root_sh;
    logic [ROOT_W+3:0] root_trial;
    logic              root_take;
    always_comb begin
        root_sh    = {r_root_rem, r_rad[RAD_W-1 -: 2]};
        root_trial = {1'b0, r_root, 2'b01};
        root_take  = root_sh >= root_trial;
    end

    // New speed and speed difference from the root.
    logic [DV_W-1:0]    raw;
    logic [DV_W-1:0]    old_ext;
    logic [DV_W-1:0]    goal_ext;
    logic [DV_W-1:0]    dv;
    logic [SPEED_W-1:0] speed_new;
    always_comb begin
        raw      = {r_root, 11'b0};
        old_ext  = {1'b0, r_old};
        goal_ext = {1'b0, r_goal};
        if (r_accel) begin
            dv        = (raw > old_ext) ? raw - old_ext : '0;
            speed_new = (raw >= goal_ext) ? r_goal : raw[SPEED_W-1:0];
        end else begin
            dv        = (old_ext > raw) ? old_ext - raw : '0;
            speed_new = (raw <= goal_ext) ? r_goal : raw[SPEED_W-1:0];
        end
        if (r_aw == '0) begin
            speed_new = r_old;
        end
    end

    // One restoring division step: one quotient bit per cycle.
    logic [ACC_W:0] div_sh;
    logic           div_take;
    always_comb begin
        div_sh   = {r_div_rem, r_num[NUM_W-1]};
        div_take = div_sh >= {1'b0, r_aw};
    end

    // Quotient clamp at 2^38 before the period product.
    localparam logic [NUM_W-1:0] R_CLAMP = NUM_W'(1) << (NUM_W - 1);
    logic [NUM_W-1:0] r_clamped;
    always_comb begin
        r_clamped = (r_num > R_CLAMP) ? R_CLAMP : r_num;
    end

    // Period from the finished product, saturated at 32 bits; all ones when no acceleration is loaded.
    logic [PROD_W-1:0] per_hi;
    logic [31:0]       period;
    always_comb begin
        per_hi = r_acc >> PER_SHIFT;
        if (r_aw == '0 || per_hi > PROD_W'(32'hFFFF_FFFF)) begin
            period = 32'hFFFF_FFFF;
        end else begin
            period = per_hi[31:0];
        end
    end

    assign o_stat.cnt_zero = (r_cnt == '0);

    // Configuration registers and motion state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step       <= CFG_RESET_VALUE;
            r_gain       <= CFG_RESET_VALUE;
            r_travel[0]  <= '0;
            r_travel[1]  <= '0;
            r_speed[0]   <= '0;
            r_speed[1]   <= '0;
            r_move       <= '0;
            r_brake_at   <= '0;
            r_goal       <= '0;
            r_brake_goal <= '0;
            r_aw         <= '0;
            r_armed      <= 1'b0;
        end else begin
            if (i_cfg_valid && i_cfg_addr == REG_STEP_DISTANCE) begin
                r_step <= i_cfg_data[CFG_W-1:0];
            end
            if (i_cfg_valid && i_cfg_addr == REG_PERIOD_GAIN) begin
                r_gain <= i_cfg_data[CFG_W-1:0];
            end
            if (i_cmd.load) begin
                r_move       <= i_move_distance;
                r_brake_at   <= i_brake_distance;
                r_goal       <= i_cruise_speed;
                r_brake_goal <= i_brake_speed;
                r_aw         <= i_accel_whole;
                r_armed      <= 1'b1;
            end
            if (i_cmd.prep_a) begin
                r_travel[r_m] <= r_travel[r_m] + DIST_W'(r_step);
            end
            if (i_cmd.prep_b && brake_fire) begin
                r_goal  <= r_brake_goal;
                r_armed <= 1'b0;
            end
            if (i_cmd.root_end) begin
                r_speed[r_m] <= speed_new;
            end
        end
    end

    // Working registers of one step.
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_m <= i_op[0];
        end
        if (i_cmd.latch || i_cmd.load) begin
            r_is_step <= i_cmd.latch;
        end
        if (i_cmd.prep_a) begin
            r_old     <= r_speed[r_m];
            r_started <= 1'b0;
        end
        if (i_cmd.prep_b) begin
            r_rem     <= r_move - r_travel[r_m];
            r_started <= brake_fire;
            r_sq      <= 34'((40'(r_old[SPEED_W-1:11]) * 40'(r_old[SPEED_W-1:11])) >> 6);
            r_as6     <= 25'((35'(r_step) * 35'(r_aw)) >> 10);
        end
        if (i_cmd.prep_c) begin
            r_accel    <= r_old < r_goal;
            r_rad      <= {1'b0, rad_sum, 6'b0};
            r_root_rem <= '0;
            r_root     <= '0;
            r_cnt      <= CNT_W'(SQRT_STEPS - 1);
        end
        if (i_cmd.root_step) begin
            r_rad <= {r_rad[RAD_W-3:0], 2'b00};
            if (root_take) begin
                r_root_rem <= (ROOT_W+2)'(root_sh - root_trial);
                r_root     <= {r_root[ROOT_W-2:0], 1'b1};
            end else begin
                r_root_rem <= root_sh[ROOT_W+1:0];
                r_root     <= {r_root[ROOT_W-2:0], 1'b0};
            end
            r_cnt <= r_cnt - 1'b1;
        end
        if (i_cmd.root_end) begin
            r_speed_out <= speed_new;
            r_num       <= {dv, 7'b0};
            r_div_rem   <= '0;
            r_cnt       <= CNT_W'(DIV_STEPS - 1);
        end
        if (i_cmd.div_step) begin
            if (div_take) begin
                r_div_rem <= ACC_W'(div_sh - {1'b0, r_aw});
                r_num     <= {r_num[NUM_W-2:0], 1'b1};
            end else begin
                r_div_rem <= div_sh[ACC_W-1:0];
                r_num     <= {r_num[NUM_W-2:0], 1'b0};
            end
            r_cnt <= r_cnt - 1'b1;
        end
        if (i_cmd.div_end) begin
            r_mul_a <= PROD_W'(r_clamped);
            r_mul_b <= TG_W'(TICK_RATE) * TG_W'(r_gain);
            r_acc   <= '0;
            r_cnt   <= CNT_W'(MUL_STEPS - 1);
        end
        if (i_cmd.mul_step) begin
            if (r_mul_b[0]) begin
                r_acc <= r_acc + r_mul_a;
            end
            r_mul_a <= {r_mul_a[PROD_W-2:0], 1'b0};
            r_mul_b <= {1'b0, r_mul_b[TG_W-1:1]};
            r_cnt   <= r_cnt - 1'b1;
        end
    end

    // Output beat register; a load returns an all-zero result.
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            if (r_is_step) begin
                o_data <= {1'b0, r_rem, r_speed_out, period};
                o_user <= {r_started, 1'b1, r_m};
            end else begin
                o_data <= '0;
                o_user <= '0;
            end
        end
    end

endmodule
`default_nettype wire

[rtl/srpg_ctrl.sv]
// Controller state machine that sequences one step or load through the datapath.
`default_nettype none
module srpg_ctrl (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_in_valid,
    input  wire [srpg_pkg::OP_W-1:0]  i_op,
    output logic                      o_in_ready,
    output logic                      o_out_valid,
    input  wire                       i_out_ready,
    input  srpg_pkg::t_stat           i_stat,
    output srpg_pkg::t_cmd            o_cmd
);
    import srpg_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_PREP_A, S_PREP_B, S_PREP_C, S_ROOT, S_ROOT_END,
        S_DIV, S_DIV_END, S_MUL, S_RESULT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_valid;
    logic   accept;
    logic   slot_free;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_valid;
    assign accept      = i_in_valid && o_in_ready;
    assign slot_free   = !r_valid || i_out_ready;

    // Commands and next state.
    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && i_op == OP_LOAD) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_RESULT;
                end else if (accept && (i_op == OP_STEP_LEFT || i_op == OP_STEP_RIGHT)) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_PREP_A;
                end
            end
            S_PREP_A: begin
                o_cmd.prep_a = 1'b1;
                n_state      = S_PREP_B;
            end
            S_PREP_B: begin
                o_cmd.prep_b = 1'b1;
                n_state      = S_PREP_C;
            end
            S_PREP_C: begin
                o_cmd.prep_c = 1'b1;
                n_state      = S_ROOT;
            end
            S_ROOT: begin
                o_cmd.root_step = 1'b1;
                if (i_stat.cnt_zero) begin
                    n_state = S_ROOT_END;
                end
            end
            S_ROOT_END: begin
                o_cmd.root_end = 1'b1;
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.cnt_zero) begin
                    n_state = S_DIV_END;
                end
            end
            S_DIV_END: begin
                o_cmd.div_end = 1'b1;
                n_state       = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul_step = 1'b1;
                if (i_stat.cnt_zero) begin
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                if (slot_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.out_load) begin
                r_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // A result is never written over a beat still waiting to be taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> slot_free)
        else $error("result written over a pending output beat");

    // An accepted step starts the preparation sequence.
    a_step_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_op == OP_STEP_LEFT || i_op == OP_STEP_RIGHT)) |=> r_state == S_PREP_A)
        else $error("step beat did not start preparation");

    // The root iteration ends into the speed update.
    a_root_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROOT && i_stat.cnt_zero) |=> r_state == S_ROOT_END)
        else $error("square root did not finish");

endmodule
`default_nettype wire

[bench/tb_stepper_ramp_profile_generator_unit.sv]
// Self-checking testbench of the two-motor stepper ramp profile generator.
`timescale 1ns / 1ps

module tb_stepper_ramp_profile_generator_unit;
    import srpg_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int unsigned RUN_LIMIT = 2000000;
    localparam int SETTLE_CYCLES = 120;

    // One predicted result beat.
    typedef struct packed {
        logic [31:0] period;
        logic [30:0] speed;
        logic [31:0] dist_left;
        logic        motor;
        logic        is_step;
        logic        brake_fired;
    } t_ramp_result;

    // Ramp predictor and store of expected result beats.
    class t_ramp_scoreboard;
        t_ramp_result pending[$];
        int unsigned  errors = 0;
        logic [31:0]  step_dist = 32'd131072;
        logic [31:0]  gain = 32'd131072;
        logic [31:0]  spd_next[2];
        logic [31:0]  travel[2];
        logic [31:0]  accel, goal, brake_at, move_total, brake_goal;
        logic         armed;

        function new();
            spd_next = '{0, 0};
            travel = '{0, 0};
            accel = 0;
            goal = 0;
            brake_at = 0;
            move_total = 0;
            brake_goal = 0;
            armed = 0;
        endfunction

        function void write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            if (idx == REG_STEP_DISTANCE) step_dist = {11'd0, val[CFG_W-1:0]};
            else if (idx == REG_PERIOD_GAIN) gain = {11'd0, val[CFG_W-1:0]};
        endfunction

        // Floor of the square root, digit by digit.
        function longint unsigned root_floor(longint unsigned x);
            longint unsigned res, bitv;
            res = 0;
            bitv = 64'd1 << 62;
            while (bitv > x) bitv >>= 2;
            while (bitv != 0) begin
                if (x >= res + bitv) begin
                    x -= res + bitv;
                    res = (res >> 1) + bitv;
                end else begin
                    res >>= 1;
                end
                bitv >>= 2;
            end
            return res;
        endfunction

        // Timer period from the speed change, saturated at all ones.
        function logic [31:0] period_of(longint unsigned dv);
            longint unsigned r;
            logic [127:0] prod;
            if (accel == 0) return 32'hFFFF_FFFF;
            r = (dv << 24) / accel;
            if (r > (64'd1 << 38)) r = 64'd1 << 38;
            prod = 128'(r) * 128'(TICK_RATE) * 128'(gain);
            prod = prod >> PER_SHIFT;
            if (prod > 128'hFFFF_FFFF) return 32'hFFFF_FFFF;
            return prod[31:0];
        endfunction

        function void note_input(logic [OP_W-1:0] op, logic [IN_DATA_W-1:0] d);
            t_ramp_result res;
            int m;
            logic [31:0] left_rem, mag;
            longint unsigned old, v6, sq, as_q, as6, raw, dv;
            res = '0;
            if (op == OP_UNUSED) return;
            if (op == OP_LOAD) begin
                move_total = d[31:0];
                brake_at = d[63:32];
                goal = {1'b0, d[94:64]};
                brake_goal = {1'b0, d[125:95]};
                accel = {4'd0, d[139:126], 14'd0} << 3;
                armed = 1;
                pending.push_back(res);
                return;
            end
            m = (op == OP_STEP_RIGHT) ? 1 : 0;
            travel[m] = travel[m] + step_dist;
            res.dist_left = move_total - travel[m];
            if (armed) begin
                left_rem = move_total - travel[0];
                mag = left_rem[31] ? (32'd0 - left_rem) : left_rem;
                if (longint'($signed(brake_at)) >= longint'({32'd0, mag})) begin
                    goal = brake_goal;
                    armed = 0;
                    res.brake_fired = 1;
                end
            end
            old = spd_next[m];
            v6 = old >> 11;
            sq = (v6 * v6) >> 6;
            as_q = (64'(step_dist) * 2 * 64'(accel)) >> 17;
            as6 = as_q >> 11;
            if (old < 64'(goal)) begin
                raw = root_floor((sq + as6) << 6) << 11;
                dv = (raw > old) ? raw - old : 0;
                spd_next[m] = (raw >= 64'(goal)) ? goal : raw[31:0];
            end else begin
                raw = (sq >= as6) ? (root_floor((sq - as6) << 6) << 11) : 0;
                dv = (old > raw) ? old - raw : 0;
                spd_next[m] = (raw <= 64'(goal)) ? goal : raw[31:0];
            end
            if (accel == 0) spd_next[m] = old[31:0];
            res.period = period_of(dv);
            res.speed = spd_next[m][30:0];
            res.motor = m[0];
            res.is_step = 1;
            pending.push_back(res);
        endfunction

        function void check(logic [OUT_DATA_W-1:0] d, logic [OUT_USER_W-1:0] u);
            t_ramp_result exp_r;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result beat data=%h user=%h", $time, d, u);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (d[31:0] !== exp_r.period) begin
                $display("%0t: step_period expected %h actual %h", $time, exp_r.period, d[31:0]);
                errors++;
            end
            if (d[62:32] !== exp_r.speed) begin
                $display("%0t: speed_now expected %h actual %h", $time, exp_r.speed, d[62:32]);
                errors++;
            end
            if (d[94:63] !== exp_r.dist_left) begin
                $display("%0t: distance_left expected %h actual %h", $time, exp_r.dist_left,
                         d[94:63]);
                errors++;
            end
            if (u[0] !== exp_r.motor) begin
                $display("%0t: motor_index expected %b actual %b", $time, exp_r.motor, u[0]);
                errors++;
            end
            if (u[1] !== exp_r.is_step) begin
                $display("%0t: is_step expected %b actual %b", $time, exp_r.is_step, u[1]);
                errors++;
            end
            if (u[2] !== exp_r.brake_fired) begin
                $display("%0t: brake_started expected %b actual %b", $time, exp_r.brake_fired,
                         u[2]);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic s_tvalid = 0;
    logic [IN_DATA_W-1:0] s_tdata = '0;
    logic [OP_W-1:0] s_tuser = '0;
    logic m_tready = 0;
    logic cfg_valid = 0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    wire s_tready, m_tvalid, cfg_ready;
    wire [OUT_DATA_W-1:0] m_tdata;
    wire [OUT_USER_W-1:0] m_tuser;

    t_ramp_scoreboard sb = new();
    int unsigned cycles = 0;
    int hold_off = 0;
    bit tx_burst = 0;

    stepper_ramp_profile_generator_unit uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(s_tvalid), .o_s_axis_tready(s_tready),
        .i_s_axis_tdata(s_tdata), .i_s_axis_tuser(s_tuser),
        .o_m_axis_tvalid(m_tvalid), .i_m_axis_tready(m_tready),
        .o_m_axis_tdata(m_tdata), .o_m_axis_tuser(m_tuser),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_addr(cfg_addr), .i_cfg_data(cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Watch accepted beats on all three channels, and the run limit.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > RUN_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
        if (i_rst_n) begin
            if (s_tvalid && s_tready) sb.note_input(s_tuser, s_tdata);
            if (m_tvalid && m_tready) sb.check(m_tdata, m_tuser);
            if (cfg_valid && cfg_ready) sb.write_reg(cfg_addr, cfg_data);
        end
    end

    // Result receiver: random stalls, and a long hold-off when asked.
    initial begin : receiver
        int gap;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
            if (hold_off > 0) gap = hold_off;
            hold_off = 0;
            if (gap > 0) begin
                m_tready <= 0;
                repeat (gap) @(posedge i_clk);
            end
            m_tready <= 1;
            do @(posedge i_clk); while (!m_tvalid);
        end
    end

    task automatic send_item(logic [OP_W-1:0] op, logic [31:0] mv, logic [31:0] bd,
                             logic [30:0] cs, logic [30:0] bs, logic [13:0] acc);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            s_tvalid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1;
        s_tuser <= op;
        s_tdata <= {4'd0, acc, bs, cs, bd, mv};
        do @(posedge i_clk); while (!s_tready);
    endtask

    task automatic send_step(logic [OP_W-1:0] op);
        send_item(op, $urandom, $urandom, $urandom, $urandom, $urandom);
    endtask

    // Wait for every expected beat, then let the block settle.
    task automatic drain();
        s_tvalid <= 0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1;
        cfg_addr <= idx;
        cfg_data <= val;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 0;
        @(posedge i_clk);
    endtask

    // A realistic move: load, then a run of steps on random motors.
    task automatic run_move();
        logic [31:0] mv, bd;
        int n;
        n = $urandom_range(8, 30);
        mv = $urandom_range(4, 200) << 17;
        bd = mv >> $urandom_range(1, 3);
        send_item(OP_LOAD, mv, bd, $urandom_range(1, 32'h0FFF_FFFF),
                  $urandom_range(0, 3) == 0 ? 31'd0 : $urandom_range(0, 32'h00FF_FFFF),
                  $urandom_range(1, 16383));
        repeat (n) begin
            send_step($urandom_range(0, 4) == 0 ? OP_STEP_RIGHT : OP_STEP_LEFT);
        end
    endtask

    initial begin : stimulus
        logic [31:0] step_set[6];
        logic [31:0] gain_set[6];
        int count;
        bit hold_done;
        bit pause_done;
        step_set = '{32'd1, 32'd1048576, 32'd131072, 32'd65536, 32'd0, 32'd0};
        gain_set = '{32'd0, 32'd1048576, 32'd131072, 32'd1, 32'd0, 32'd0};
        hold_done = 0;
        pause_done = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: steps with no acceleration loaded, unused opcode, extreme loads.
        send_step(OP_STEP_LEFT);
        send_step(OP_STEP_RIGHT);
        send_step(OP_UNUSED);
        send_item(OP_LOAD, 32'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
                  14'd16383);
        repeat (4) send_step(OP_STEP_LEFT);
        send_item(OP_LOAD, 32'h8000_0000, 32'h7FFF_FFFF, 31'd0, 31'd0, 14'd1);
        repeat (3) send_step(OP_STEP_RIGHT);
        send_item(OP_LOAD, 32'd0, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 31'd0, 14'd16383);
        repeat (4) send_step(OP_STEP_LEFT);
        send_item(OP_LOAD, 32'd10 << 17, 32'd3 << 17, 31'h0100_0000, 31'd0, 14'd9000);
        repeat (6) send_step(OP_STEP_LEFT);
        send_step(OP_STEP_RIGHT);
        drain();

        // Random phases, each under its own register setting.
        for (int ph = 0; ph < 6; ph++) begin
            cfg_write(REG_STEP_DISTANCE, ph < 4 ? step_set[ph] : $urandom_range(1, 1048576));
            cfg_write(REG_PERIOD_GAIN, ph < 4 ? gain_set[ph] : $urandom_range(0, 1048576));
            count = 0;
            while (count < 140) begin
                tx_burst = ($urandom_range(0, 5) == 0);
                // Long receiver hold-off while the sender keeps offering beats.
                if (ph == 2 && count >= 40 && !hold_done) begin
                    hold_off = 400;
                    hold_done = 1;
                end
                // Sender pause until every expected beat has come back.
                if (ph == 3 && count >= 70 && !pause_done) begin
                    drain();
                    pause_done = 1;
                end
                case ($urandom_range(0, 9))
                    0: begin
                        send_step(OP_LOAD);
                        count++;
                    end
                    1: send_step(OP_UNUSED);
                    2: begin
                        send_step($urandom_range(0, 1) ? OP_STEP_RIGHT : OP_STEP_LEFT);
                        count++;
                    end
                    default: begin
                        run_move();
                        count += 20;
                    end
                endcase
            end
            tx_burst = 0;
            drain();
        end

        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

[files.f]
rtl/srpg_pkg.sv
rtl/srpg_datapath.sv
rtl/srpg_ctrl.sv
rtl/stepper_ramp_profile_generator_unit.sv
bench/tb_stepper_ramp_profile_generator_unit.sv
